[design/oer_pkg.sv]
`default_nettype none

package oer_pkg;

  localparam int unsigned RingDepthDef = 4096;
  localparam int unsigned MaxBatchDef  = 64;

  localparam int unsigned SeqW   = 64;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned RecW   = 64;
  localparam int unsigned LayerW = 8;
  localparam int unsigned FlagW  = 8;
  localparam int unsigned EffW   = 32;
  localparam int unsigned DropW  = 64;
  localparam int unsigned CntW   = 10;
  localparam int unsigned LimitW = 7;
  localparam int unsigned WordW  = SeqW + TimeW + RecW + LayerW + FlagW + EffW;

  // request tdata layout, lowest bit first
  localparam int unsigned TimeLo     = 0;
  localparam int unsigned RecLo      = TimeLo + TimeW;
  localparam int unsigned LayerLo    = RecLo + RecW;
  localparam int unsigned FlagLo     = LayerLo + LayerW;
  localparam int unsigned BackstopLo = FlagLo + FlagW;
  localparam int unsigned TagLo      = BackstopLo + 1;
  localparam int unsigned CounterLo  = TagLo + CntW;
  localparam int unsigned ReportLo   = CounterLo + CntW;
  localparam int unsigned PromptLo   = ReportLo + CntW;
  localparam int unsigned LimitLo    = PromptLo + CntW;
  localparam int unsigned InRawW     = LimitLo + LimitW;
  localparam int unsigned InTdataW   = ((InRawW + 7) / 8) * 8;

  localparam logic [FlagW-1:0] BackstopMaskRst = 8'h80;
  localparam logic [7:0]       SatMax          = 8'hff;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_POPPED = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_PUSHED = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  function automatic logic [7:0] sat8(input logic [CntW-1:0] v);
    sat8 = (v > CntW'(SatMax)) ? SatMax : v[7:0];
  endfunction

endpackage

`default_nettype wire

[design/overwrite_oldest_event_ring.sv]
// Overwrite-oldest event trace ring.
// Requests enter on s_axis (tuser = func: push or pop). A push stores one
// record at the write pointer, stamped with a running sequence number, and
// returns one result echoing the stored record. A pop returns up to
// pop_limit of the oldest records (capped to MAX_BATCH), tlast on the final
// one; popping an empty ring returns one empty result.
// Results leave on m_axis (tuser = status). Each carries the overwrite total
// and the live count after its own operation.
// Path: a request passes the stage registers (with the memory read data
// register for pops) and then the output register. Pushes are taken one per
// cycle while the output buffer has room. A pop issues one memory read
// per cycle while there is room, holding the request side until its last
// read; the single read port of the record memory sets that rate.
// Reset empties the ring, clears the pointers and counters and sets the
// backstop mask to 0x80; the record memory is not cleared.
// When the receiver stalls, up to two results wait in the output buffer,
// after which s_axis_tready_o drops and pops pause until space frees.
`default_nettype none

module overwrite_oldest_event_ring
  import oer_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RingDepthDef,
  parameter int unsigned MAX_BATCH  = MaxBatchDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                cfg_we_i,
  input  wire logic [FlagW-1:0]    cfg_wdata_i,     // backstop_mask

  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // time_ns, record_word, layer, flags, backstop, tag_count, counter_count,
  // report_count, prompt_count, pop_limit
  input  wire logic [InTdataW-1:0] s_axis_tdata_i,
  input  wire logic                s_axis_tuser_i,  // func

  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // seq, time_out, record_out, layer_out, flags_out, effects, dropped_total,
  // live_records
  output logic [((WordW + DropW + $clog2(RING_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                   m_axis_tdata_o,
  output logic [1:0]               m_axis_tuser_o,  // status
  output logic                     m_axis_tlast_o
);

  localparam int unsigned PtrW   = $clog2(RING_DEPTH);
  localparam int unsigned LiveW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned BatchW = $clog2(MAX_BATCH + 1);
  localparam int unsigned OutW   = ((WordW + DropW + LiveW + 7) / 8) * 8;

  typedef struct packed {
    status_e             status;
    logic                last;
    logic [WordW-1:0]    word;
    logic [DropW-1:0]    dropped;
    logic [LiveW-1:0]    live;
  } result_t;

  logic [WordW-1:0] mem_q [RING_DEPTH];
  logic [WordW-1:0] rdata_q;
  logic             mem_we, mem_re;

  state_e            state_q, state_d;
  logic [PtrW-1:0]   wp_q, wp_d, rp_q, rp_d, wp_inc, rp_inc;
  logic [LiveW-1:0]  live_q, live_d;
  logic [SeqW-1:0]   seq_q, seq_d;
  logic [DropW-1:0]  drop_q, drop_d;
  logic [FlagW-1:0]  mask_q, mask_d;
  logic [BatchW-1:0] rem_q, rem_d, rem_cur, lim;

  logic    s1_valid_q, s1_valid_d, s1_rd_q, s1_rd_d;
  result_t s1_res_q, s1_res_d, enq_res;

  result_t    head_q, head_d, skid_q, skid_d;
  logic [1:0] cnt_q, cnt_d;

  logic             deq, enq, can_issue, acc, last_pop;
  logic [2:0]       occ;
  logic [LimitW-1:0] lim_in;
  logic [FlagW-1:0] fl;
  logic [EffW-1:0]  eff;
  logic [WordW-1:0] push_word;

  assign lim_in = s_axis_tdata_i[LimitLo +: LimitW];
  assign fl = s_axis_tdata_i[FlagLo +: FlagW]
            | (s_axis_tdata_i[BackstopLo] ? mask_q : '0);
  assign eff = {sat8(s_axis_tdata_i[PromptLo +: CntW]),
                sat8(s_axis_tdata_i[ReportLo +: CntW]),
                sat8(s_axis_tdata_i[CounterLo +: CntW]),
                sat8(s_axis_tdata_i[TagLo +: CntW])};
  assign push_word = {eff, fl, s_axis_tdata_i[LayerLo +: LayerW],
                      s_axis_tdata_i[RecLo +: RecW], s_axis_tdata_i[TimeLo +: TimeW], seq_q};

  assign wp_inc = (wp_q == PtrW'(RING_DEPTH - 1)) ? '0 : wp_q + PtrW'(1);
  assign rp_inc = (rp_q == PtrW'(RING_DEPTH - 1)) ? '0 : rp_q + PtrW'(1);

  always_comb begin
    if (lim_in == '0) begin
      lim = BatchW'(1);
    end else if (lim_in > LimitW'(MAX_BATCH)) begin
      lim = BatchW'(MAX_BATCH);
    end else begin
      lim = BatchW'(lim_in);
    end
  end

  assign deq       = (cnt_q != 2'd0) && m_axis_tready_i;
  assign occ       = 3'(cnt_q) + 3'(s1_valid_q) - 3'(deq);
  assign can_issue = occ < 3'd2;
  assign s_axis_tready_o = (state_q == ST_IDLE) && can_issue;
  assign acc       = s_axis_tvalid_i && s_axis_tready_o;
  assign rem_cur   = (state_q == ST_IDLE) ? lim : rem_q;
  assign last_pop  = (rem_cur == BatchW'(1)) || (live_q == LiveW'(1));

  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    rp_d       = rp_q;
    live_d     = live_q;
    seq_d      = seq_q;
    drop_d     = drop_q;
    rem_d      = rem_q;
    mask_d     = cfg_we_i ? cfg_wdata_i : mask_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    s1_valid_d = 1'b0;
    s1_rd_d    = 1'b0;
    s1_res_d   = s1_res_q;

    priority if (acc && (s_axis_tuser_i == FUNC_PUSH)) begin
      mem_we = 1'b1;
      seq_d  = seq_q + SeqW'(1);
      wp_d   = wp_inc;
      if (live_q == LiveW'(RING_DEPTH)) begin
        drop_d = drop_q + DropW'(1);
        rp_d   = rp_inc;
      end else begin
        live_d = live_q + LiveW'(1);
      end
      s1_valid_d       = 1'b1;
      s1_res_d.status  = STATUS_PUSHED;
      s1_res_d.last    = 1'b1;
      s1_res_d.word    = push_word;
      s1_res_d.dropped = drop_d;
      s1_res_d.live    = live_d;
    end else if (acc && (live_q == '0)) begin
      s1_valid_d       = 1'b1;
      s1_res_d.status  = STATUS_EMPTY;
      s1_res_d.last    = 1'b1;
      s1_res_d.word    = '0;
      s1_res_d.dropped = drop_q;
      s1_res_d.live    = live_q;
    end else if (acc || ((state_q == ST_POP) && can_issue)) begin
      mem_re           = 1'b1;
      rp_d             = rp_inc;
      live_d           = live_q - LiveW'(1);
      rem_d            = rem_cur - BatchW'(1);
      state_d          = last_pop ? ST_IDLE : ST_POP;
      s1_valid_d       = 1'b1;
      s1_rd_d          = 1'b1;
      s1_res_d.status  = STATUS_POPPED;
      s1_res_d.last    = last_pop;
      s1_res_d.word    = '0;
      s1_res_d.dropped = drop_q;
      s1_res_d.live    = live_d;
    end else begin
      state_d = state_q;
    end
  end

  // output buffer: head register plus one skid entry
  always_comb begin
    enq_res = s1_res_q;
    if (s1_rd_q) begin
      enq_res.word = rdata_q;
    end
    enq    = s1_valid_q;
    head_d = head_q;
    skid_d = skid_q;
    cnt_d  = cnt_q + 2'(enq) - 2'(deq);
    unique case (cnt_q)
      2'd0: begin
        if (enq) begin
          head_d = enq_res;
        end
      end
      2'd1: begin
        if (enq && deq) begin
          head_d = enq_res;
        end else if (enq) begin
          skid_d = enq_res;
        end
      end
      default: begin
        if (deq) begin
          head_d = skid_q;
          if (enq) begin
            skid_d = enq_res;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= push_word;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wp_q       <= '0;
      rp_q       <= '0;
      live_q     <= '0;
      seq_q      <= '0;
      drop_q     <= '0;
      rem_q      <= '0;
      mask_q     <= BackstopMaskRst;
      s1_valid_q <= 1'b0;
      s1_rd_q    <= 1'b0;
      cnt_q      <= 2'd0;
    end else begin
      state_q    <= state_d;
      wp_q       <= wp_d;
      rp_q       <= rp_d;
      live_q     <= live_d;
      seq_q      <= seq_d;
      drop_q     <= drop_d;
      rem_q      <= rem_d;
      mask_q     <= mask_d;
      s1_valid_q <= s1_valid_d;
      s1_rd_q    <= s1_rd_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_res_q <= s1_res_d;
    head_q   <= head_d;
    skid_q   <= skid_d;
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = OutW'({head_q.live, head_q.dropped, head_q.word});
  assign m_axis_tuser_o  = head_q.status;
  assign m_axis_tlast_o  = head_q.last;

endmodule

`default_nettype wire
